// File: src/sfd_pkg.sv
// Shared constants, types and helper functions of the stereo feedback delay.
// Used by every module in src; depends on nothing.
`default_nettype none

package sfd_pkg;

  // Store geometry and sample format.
  localparam int unsigned DEPTH      = 32768;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned Q_FRAC     = 15;
  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(32768);

  // Serial multiplier: one four-bit digit of the gain per cycle.
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned NUM_DIGITS = GAIN_W / DIGIT_W;
  localparam int unsigned DCNT_W     = $clog2(NUM_DIGITS);
  localparam int unsigned ACC_W      = 32;

  // Configuration port.
  localparam int unsigned PADDR_W    = 5;
  localparam int unsigned PDATA_W    = 32;
  localparam int unsigned RIDX_W     = 3;

  // Register indexes (byte address divided by four).
  localparam logic [RIDX_W-1:0] REG_ACTIVE_LENGTH = 3'd0;
  localparam logic [RIDX_W-1:0] REG_DELAY_SAMPLES = 3'd1;
  localparam logic [RIDX_W-1:0] REG_FEEDBACK_GAIN = 3'd2;
  localparam logic [RIDX_W-1:0] REG_CROSS_MIX     = 3'd3;
  localparam logic [RIDX_W-1:0] REG_OUTPUT_VOLUME = 3'd4;

  // Register contents as seen by the datapath.
  typedef struct packed {
    logic [LEN_W-1:0]  active_length;
    logic [ADDR_W-1:0] delay_samples;
    logic [GAIN_W-1:0] feedback_gain;
    logic [GAIN_W-1:0] cross_mix;
    logic [GAIN_W-1:0] output_volume;
  } cfg_t;

  // One write into both delay stores.
  typedef struct packed {
    logic                       en;
    logic [ADDR_W-1:0]          addr;
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } store_wr_t;

  // Gains above one are taken as one.
  function automatic logic [GAIN_W-1:0] clamp_gain(input logic [GAIN_W-1:0] g);
    return (g > GAIN_ONE) ? GAIN_ONE : g;
  endfunction

  // Clamp a sum that grew by one bit back into the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [SAMPLE_W:0] s);
    logic signed [SAMPLE_W-1:0] r;
    if (s[SAMPLE_W] != s[SAMPLE_W-1]) begin
      r = s[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else begin
      r = s[SAMPLE_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: src/sfd_mac.sv
// Digit-serial multiply-accumulate: two signed samples times two unsigned
// gain digits per cycle while enabled, most significant digit first. Uses sfd_pkg.
`default_nettype none

module sfd_mac
  import sfd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       first_i,
  input  wire logic signed [SAMPLE_W-1:0] a_i,
  input  wire logic [DIGIT_W-1:0]         da_i,
  input  wire logic signed [SAMPLE_W-1:0] b_i,
  input  wire logic [DIGIT_W-1:0]         db_i,
  output logic signed [ACC_W-1:0]         acc_o
);

  localparam int unsigned PROD_W = SAMPLE_W + DIGIT_W + 1;

  logic signed [DIGIT_W:0]   da_s, db_s;
  logic signed [PROD_W-1:0]  pa, pb;
  logic signed [ACC_W-1:0]   base, acc_d, acc_q;

  // Digits are unsigned, so they get a zero sign bit.
  assign da_s = {1'b0, da_i};
  assign db_s = {1'b0, db_i};
  assign pa   = a_i * da_s;
  assign pb   = b_i * db_s;

  // Horner step: shift the partial sum by one digit and add both products.
  assign base  = first_i ? '0 : {acc_q[ACC_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
  assign acc_d = base + {{(ACC_W-PROD_W){pa[PROD_W-1]}}, pa}
                      + {{(ACC_W-PROD_W){pb[PROD_W-1]}}, pb};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (en_i) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

`default_nettype wire

// File: src/sfd_ptrmod.sv
// Bit-serial remainder unit that reduces the read pointer modulo the
// active length, one pointer bit per cycle. Uses sfd_pkg.
`default_nettype none

module sfd_ptrmod
  import sfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [ADDR_W-1:0] num_i,
  input  wire logic [LEN_W-1:0]  den_i,
  output logic                   done_o,
  output logic [ADDR_W-1:0]      rem_o
);

  localparam int unsigned CNT_W = $clog2(ADDR_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(ADDR_W - 1);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [ADDR_W-1:0]   num_q, num_d;
  logic [LEN_W-1:0]    rem_q, rem_d;
  logic [LEN_W:0]      trial;

  // Bring down the next pointer bit and subtract the length if it fits.
  assign trial = {rem_q, num_q[ADDR_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = num_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, den_i}) ? LEN_W'(trial - {1'b0, den_i})
                                       : trial[LEN_W-1:0];
      num_d = {num_q[ADDR_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[ADDR_W-1:0];

endmodule

`default_nettype wire

// File: src/sfd_store.sv
// Both delay stores side by side in one memory, with the clearing pass
// that zeroes every entry after reset. Uses sfd_pkg.
`default_nettype none

module sfd_store
  import sfd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire store_wr_t                  wr_i,
  input  wire logic                       rd_en_i,
  input  wire logic [ADDR_W-1:0]          rd_addr_i,
  output logic signed [SAMPLE_W-1:0]      rd_left_o,
  output logic signed [SAMPLE_W-1:0]      rd_right_o,
  output logic                            busy_o
);

  localparam int unsigned WORD_W = 2 * SAMPLE_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [ADDR_W:0]   clr_q, clr_d;
  logic              we;
  logic [ADDR_W-1:0] wa;
  logic [WORD_W-1:0] wd;

  // The clearing counter runs until its top bit sets.
  assign busy_o = !clr_q[ADDR_W];
  assign clr_d  = busy_o ? clr_q + (ADDR_W+1)'(1) : clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  // The clearing pass owns the write port while it runs.
  assign we = busy_o || wr_i.en;
  assign wa = busy_o ? clr_q[ADDR_W-1:0] : wr_i.addr;
  assign wd = busy_o ? '0 : {wr_i.left, wr_i.right};

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Registered read; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_left_o  = rd_q[WORD_W-1:SAMPLE_W];
  assign rd_right_o = rd_q[SAMPLE_W-1:0];

endmodule

`default_nettype wire

// File: src/sfd_regs.sv
// APB-style register file holding the five configuration registers.
// Uses sfd_pkg.
`default_nettype none

module sfd_regs
  import sfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready,
  output cfg_t                    cfg_o
);

  cfg_t              cfg_q, cfg_d;
  logic [RIDX_W-1:0] idx;
  logic              wr_en;

  assign idx    = paddr[PADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write decode; an index beyond the list changes nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ACTIVE_LENGTH: cfg_d.active_length = pwdata[LEN_W-1:0];
        REG_DELAY_SAMPLES: cfg_d.delay_samples = pwdata[ADDR_W-1:0];
        REG_FEEDBACK_GAIN: cfg_d.feedback_gain = pwdata[GAIN_W-1:0];
        REG_CROSS_MIX:     cfg_d.cross_mix     = pwdata[GAIN_W-1:0];
        REG_OUTPUT_VOLUME: cfg_d.output_volume = pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_length <= LEN_W'(32768);
      cfg_q.delay_samples <= ADDR_W'(1);
      cfg_q.feedback_gain <= GAIN_W'(1638);
      cfg_q.cross_mix     <= '0;
      cfg_q.output_volume <= GAIN_ONE;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read decode.
  always_comb begin
    unique case (idx)
      REG_ACTIVE_LENGTH: prdata = PDATA_W'(cfg_q.active_length);
      REG_DELAY_SAMPLES: prdata = PDATA_W'(cfg_q.delay_samples);
      REG_FEEDBACK_GAIN: prdata = PDATA_W'(cfg_q.feedback_gain);
      REG_CROSS_MIX:     prdata = PDATA_W'(cfg_q.cross_mix);
      REG_OUTPUT_VOLUME: prdata = PDATA_W'(cfg_q.output_volume);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: src/stereo_feedback_delay.sv
// Top level of the stereo feedback delay with cross-feed: control sequencer,
// output register and the instances of sfd_regs, sfd_store, sfd_ptrmod, sfd_mac.
// Uses sfd_pkg.
//
//   Channel  Handshake                  Payload
//   input    in_valid_i / in_stall_o    in_left_i, in_right_i, acc_left_i, acc_right_i
//   output   out_valid_o / out_stall_i  out_left_o, out_right_o
//   config   psel, penable, pwrite      paddr, pwdata, prdata, pready
//
// After acceptance an item passes through a store read, a digit-serial pass for the
// volume and mix products, one for the feedback products, and a write-back before
// the next item can be accepted.
// If the active length was lowered to or below the read pointer, a bit-serial
// remainder step runs before the store read of the next item.
// After reset the stores are zeroed by a clearing pass over all 32768 entries; input
// is stalled during the pass, configuration writes are taken.
// A stalled result waits in the output register while the next item is worked.
`default_nettype none

module stereo_feedback_delay
  import sfd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic signed [SAMPLE_W-1:0] in_left_i,
  input  wire logic signed [SAMPLE_W-1:0] in_right_i,
  input  wire logic signed [SAMPLE_W-1:0] acc_left_i,
  input  wire logic signed [SAMPLE_W-1:0] acc_right_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0]      out_left_o,
  output logic signed [SAMPLE_W-1:0]      out_right_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output logic [PDATA_W-1:0]              prdata,
  output logic                            pready
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MOD   = 7'b0000010,
    S_READ  = 7'b0000100,
    S_MULA  = 7'b0001000,
    S_MULB  = 7'b0010000,
    S_WRITE = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_e;

  localparam logic [DCNT_W-1:0] LAST_DIGIT = DCNT_W'(NUM_DIGITS - 1);

  state_e state_q, state_d;

  cfg_t              cfg;
  store_wr_t         store_wr;
  logic              store_busy;
  logic              rd_en;
  logic signed [SAMPLE_W-1:0] rd_left, rd_right;

  logic              mod_start, mod_done;
  logic [ADDR_W-1:0] mod_rem;

  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic [ADDR_W-1:0] wr_q, wr_d;
  logic [GAIN_W-1:0] vol_q, vol_d, cr_q, cr_d, ncr_q, ncr_d, fb_q, fb_d;
  logic signed [SAMPLE_W-1:0] il_q, ir_q, al_q, ar_q;

  logic              out_valid_q, out_valid_d;
  logic signed [SAMPLE_W-1:0] out_left_q, out_right_q;
  logic              out_load, out_free, accept;

  logic [LEN_W-1:0]  len, len_m1;
  logic [ADDR_W-1:0] dly;
  logic [LEN_W-1:0]  wr_sum, ptr_inc;

  logic              mac_a_en, mac_b_en, mac_first;
  logic [DIGIT_W-1:0] d_vol, d_cr, d_ncr, d_fb;
  logic signed [ACC_W-1:0] acc_vl, acc_vr, acc_ml, acc_mr, acc_fl, acc_fr;
  logic signed [SAMPLE_W-1:0] mix_l, mix_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r, sto_l, sto_r;

  // Configuration registers.
  sfd_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective ring length, clamped to the store depth and at least two.
  always_comb begin
    if (cfg.active_length < LEN_W'(2)) begin
      len = LEN_W'(2);
    end else if (cfg.active_length > LEN_W'(DEPTH)) begin
      len = LEN_W'(DEPTH);
    end else begin
      len = cfg.active_length;
    end
  end

  // Delay saturates at length minus one; the write slot wraps once at most.
  assign len_m1  = len - LEN_W'(1);
  assign dly     = ({1'b0, cfg.delay_samples} > len_m1) ? len_m1[ADDR_W-1:0]
                                                        : cfg.delay_samples;
  assign wr_sum  = {1'b0, pos_q} + {1'b0, dly};
  assign ptr_inc = {1'b0, pos_q} + LEN_W'(1);

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || store_busy;
  assign mod_start  = accept && ({1'b0, ptr_q} >= len);

  // Pointer reduction after the length was lowered.
  sfd_ptrmod u_ptrmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .num_i   (ptr_q),
    .den_i   (len),
    .done_o  (mod_done),
    .rem_o   (mod_rem)
  );

  // Delay stores.
  assign rd_en          = (state_q == S_READ);
  assign store_wr.en    = (state_q == S_WRITE);
  assign store_wr.addr  = wr_q;
  assign store_wr.left  = sto_l;
  assign store_wr.right = sto_r;

  sfd_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (store_wr),
    .rd_en_i    (rd_en),
    .rd_addr_i  (pos_q),
    .rd_left_o  (rd_left),
    .rd_right_o (rd_right),
    .busy_o     (store_busy)
  );

  // Gain digits, most significant first.
  assign d_vol     = vol_q[GAIN_W-1 -: DIGIT_W];
  assign d_cr      = cr_q[GAIN_W-1 -: DIGIT_W];
  assign d_ncr     = ncr_q[GAIN_W-1 -: DIGIT_W];
  assign d_fb      = fb_q[GAIN_W-1 -: DIGIT_W];
  assign mac_a_en  = (state_q == S_MULA);
  assign mac_b_en  = (state_q == S_MULB);
  assign mac_first = (dcnt_q == '0);

  // First pass: volume products and the two cross-blended mixes.
  sfd_mac u_mac_vl (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_a_en), .first_i (mac_first),
    .a_i (rd_left), .da_i (d_vol), .b_i ('0), .db_i ('0), .acc_o (acc_vl)
  );

  sfd_mac u_mac_vr (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_a_en), .first_i (mac_first),
    .a_i (rd_right), .da_i (d_vol), .b_i ('0), .db_i ('0), .acc_o (acc_vr)
  );

  sfd_mac u_mac_ml (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_a_en), .first_i (mac_first),
    .a_i (rd_left), .da_i (d_ncr), .b_i (rd_right), .db_i (d_cr), .acc_o (acc_ml)
  );

  sfd_mac u_mac_mr (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_a_en), .first_i (mac_first),
    .a_i (rd_left), .da_i (d_cr), .b_i (rd_right), .db_i (d_ncr), .acc_o (acc_mr)
  );

  // Floor division by one in Q1.15 is an arithmetic shift; the range fits.
  assign mix_l = acc_ml[Q_FRAC+SAMPLE_W-1:Q_FRAC];
  assign mix_r = acc_mr[Q_FRAC+SAMPLE_W-1:Q_FRAC];

  // Second pass: feedback gain on the mixes.
  sfd_mac u_mac_fl (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_b_en), .first_i (mac_first),
    .a_i (mix_l), .da_i (d_fb), .b_i ('0), .db_i ('0), .acc_o (acc_fl)
  );

  sfd_mac u_mac_fr (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (mac_b_en), .first_i (mac_first),
    .a_i (mix_r), .da_i (d_fb), .b_i ('0), .db_i ('0), .acc_o (acc_fr)
  );

  // Saturated results and store values.
  assign res_l = sat_sample({al_q[SAMPLE_W-1], al_q}
                 + {acc_vl[Q_FRAC+SAMPLE_W-1], acc_vl[Q_FRAC+SAMPLE_W-1:Q_FRAC]});
  assign res_r = sat_sample({ar_q[SAMPLE_W-1], ar_q}
                 + {acc_vr[Q_FRAC+SAMPLE_W-1], acc_vr[Q_FRAC+SAMPLE_W-1:Q_FRAC]});
  assign sto_l = sat_sample({il_q[SAMPLE_W-1], il_q}
                 + {acc_fl[Q_FRAC+SAMPLE_W-1], acc_fl[Q_FRAC+SAMPLE_W-1:Q_FRAC]});
  assign sto_r = sat_sample({ir_q[SAMPLE_W-1], ir_q}
                 + {acc_fr[Q_FRAC+SAMPLE_W-1], acc_fr[Q_FRAC+SAMPLE_W-1:Q_FRAC]});

  assign out_free = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    dcnt_d   = dcnt_q;
    ptr_d    = ptr_q;
    pos_d    = pos_q;
    wr_d     = wr_q;
    vol_d    = vol_q;
    cr_d     = cr_q;
    ncr_d    = ncr_q;
    fb_d     = fb_q;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          pos_d   = ptr_q;
          state_d = mod_start ? S_MOD : S_READ;
        end
      end
      S_MOD: begin
        if (mod_done) begin
          pos_d   = mod_rem;
          state_d = S_READ;
        end
      end
      S_READ: begin
        wr_d    = (wr_sum >= len) ? ADDR_W'(wr_sum - len) : wr_sum[ADDR_W-1:0];
        vol_d   = clamp_gain(cfg.output_volume);
        cr_d    = clamp_gain(cfg.cross_mix);
        ncr_d   = GAIN_ONE - clamp_gain(cfg.cross_mix);
        fb_d    = clamp_gain(cfg.feedback_gain);
        dcnt_d  = '0;
        state_d = S_MULA;
      end
      S_MULA: begin
        vol_d  = {vol_q[GAIN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        cr_d   = {cr_q[GAIN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        ncr_d  = {ncr_q[GAIN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == LAST_DIGIT) begin
          state_d = S_MULB;
        end
      end
      S_MULB: begin
        fb_d   = {fb_q[GAIN_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == LAST_DIGIT) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        ptr_d = (ptr_inc >= len) ? '0 : ptr_inc[ADDR_W-1:0];
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Output register: holds a result until it is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    wr_q  <= wr_d;
    vol_q <= vol_d;
    cr_q  <= cr_d;
    ncr_q <= ncr_d;
    fb_q  <= fb_d;
    if (accept) begin
      il_q <= in_left_i;
      ir_q <= in_right_i;
      al_q <= acc_left_i;
      ar_q <= acc_right_i;
    end
    if (out_load) begin
      out_left_q  <= res_l;
      out_right_q <= res_r;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;

`ifndef SYNTHESIS
  // No item writes the stores while the clearing pass runs.
  a_no_write_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_wr.en |-> !store_busy)
    else $error("store write during clearing pass");

  // An accepted item goes to the read or to the pointer reduction.
  a_accept_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_READ || state_q == S_MOD))
    else $error("accepted item not started");

  // The remainder unit reports only while the sequencer waits for it.
  a_mod_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> (state_q == S_MOD))
    else $error("pointer reduction finished outside its state");

  // After write-back the pointer lies inside the ring.
  a_ptr_in_ring : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> ({1'b0, ptr_q} < $past(len)))
    else $error("read pointer outside the active length");
`endif

endmodule

`default_nettype wire

// File: verif/tb_top.sv
// Self-checking testbench of stereo_feedback_delay: directed and random stereo items
// checked against a cycle-free predictor of the echo stores, with APB register writes
// and read-back between phases. Depends on src/sfd_pkg.sv and the RTL under src.
`timescale 1ns / 1ps

module tb_top;
  import sfd_pkg::*;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One result item: both accumulator sums.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } stereo_t;

  // Amplitude styles for random items and pattern styles of the receiver.
  typedef enum int {AMP_FULL, AMP_EDGE, AMP_QUIET} amp_mode_t;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_BURSTS} rx_mode_t;

  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
  localparam longint UNITY = longint'(GAIN_ONE);
  localparam int unsigned MIN_LENGTH = 2;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;
  localparam int ITEM_CYCLES = 11;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  sample_t in_left_i = '0;
  sample_t in_right_i = '0;
  sample_t acc_left_i = '0;
  sample_t acc_right_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  sample_t out_left_o;
  sample_t out_right_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  // Predictor state: echo stores, ring pointer and register copies.
  sample_t echo_l [DEPTH];
  sample_t echo_r [DEPTH];
  int unsigned ring_ptr = 0;
  logic [LEN_W-1:0] reg_len = 16'd32768;
  logic [ADDR_W-1:0] reg_delay = 15'd1;
  logic [GAIN_W-1:0] reg_fb = 16'd1638;
  logic [GAIN_W-1:0] reg_cross = 16'd0;
  logic [GAIN_W-1:0] reg_vol = 16'd32768;

  stereo_t mixed_q[$];
  int fail_count = 0;
  int burst_left = 0;
  rx_mode_t rx_mode = RX_OPEN;
  int rx_left = 0;

  stereo_feedback_delay DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_left_i   (in_left_i),
    .in_right_i  (in_right_i),
    .acc_left_i  (acc_left_i),
    .acc_right_i (acc_right_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_left_o  (out_left_o),
    .out_right_o (out_right_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Only the first ten failures are shown; the rest are counted.
  task automatic flag_error(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
  endtask

  function automatic sample_t clip_sample(input longint v);
    if (v > SAMPLE_MAX) return sample_t'(SAMPLE_MAX);
    if (v < SAMPLE_MIN) return sample_t'(SAMPLE_MIN);
    return sample_t'(v);
  endfunction

  // Gains above one act as exactly one.
  function automatic longint limit_gain(input logic [GAIN_W-1:0] g);
    return (longint'(g) > UNITY) ? UNITY : longint'(g);
  endfunction

  // Works out the result of one accepted item and updates the echo stores.
  // Arithmetic right shifts of signed products round toward minus infinity.
  function automatic void predict_echo(input sample_t in_l, input sample_t in_r,
                                       input sample_t acc_l, input sample_t acc_r);
    int unsigned len, dly, pos, wr;
    longint fb, cr, vol, tap_l, tap_r, mix_l, mix_r;
    stereo_t res;
    len = reg_len;
    if (len < MIN_LENGTH) len = MIN_LENGTH;
    if (len > DEPTH) len = DEPTH;
    fb = limit_gain(reg_fb);
    cr = limit_gain(reg_cross);
    vol = limit_gain(reg_vol);
    pos = ring_ptr % len;
    dly = reg_delay;
    if (dly > len - 1) dly = len - 1;
    wr = pos + dly;
    if (wr >= len) wr -= len;
    // Both taps are read before the write, which matters at zero delay.
    tap_l = echo_l[pos];
    tap_r = echo_r[pos];
    res.left = clip_sample(acc_l + ((tap_l * vol) >>> Q_FRAC));
    res.right = clip_sample(acc_r + ((tap_r * vol) >>> Q_FRAC));
    mixed_q.push_back(res);
    mix_l = (tap_l * (UNITY - cr) + tap_r * cr) >>> Q_FRAC;
    mix_r = (tap_l * cr + tap_r * (UNITY - cr)) >>> Q_FRAC;
    echo_l[wr] = clip_sample(in_l + ((fb * mix_l) >>> Q_FRAC));
    echo_r[wr] = clip_sample(in_r + ((fb * mix_r) >>> Q_FRAC));
    pos++;
    if (pos >= len) pos = 0;
    ring_ptr = pos;
  endfunction

  function automatic logic [PDATA_W-1:0] register_image(input logic [RIDX_W-1:0] idx);
    case (idx)
      REG_ACTIVE_LENGTH: return PDATA_W'(reg_len);
      REG_DELAY_SAMPLES: return PDATA_W'(reg_delay);
      REG_FEEDBACK_GAIN: return PDATA_W'(reg_fb);
      REG_CROSS_MIX:     return PDATA_W'(reg_cross);
      REG_OUTPUT_VOLUME: return PDATA_W'(reg_vol);
      default:           return '0;
    endcase
  endfunction

  // One APB transfer: setup cycle, access cycle, then back to idle.
  task automatic apb_access(input logic [RIDX_W-1:0] idx, input logic wr,
                            input logic [PDATA_W-1:0] data,
                            output logic [PDATA_W-1:0] rdata);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= PADDR_W'({idx, 2'b00});
    if (wr) pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_register(input logic [RIDX_W-1:0] idx,
                                input logic [PDATA_W-1:0] data);
    logic [PDATA_W-1:0] unused;
    apb_access(idx, 1'b1, data, unused);
    case (idx)
      REG_ACTIVE_LENGTH: reg_len = data[LEN_W-1:0];
      REG_DELAY_SAMPLES: reg_delay = data[ADDR_W-1:0];
      REG_FEEDBACK_GAIN: reg_fb = data[GAIN_W-1:0];
      REG_CROSS_MIX:     reg_cross = data[GAIN_W-1:0];
      REG_OUTPUT_VOLUME: reg_vol = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // Reads every defined register back and compares with the written value.
  task automatic check_registers();
    logic [PDATA_W-1:0] got;
    for (int i = REG_ACTIVE_LENGTH; i <= REG_OUTPUT_VOLUME; i++) begin
      apb_access(RIDX_W'(i), 1'b0, '0, got);
      if (got !== register_image(RIDX_W'(i))) begin
        flag_error($sformatf("register %0d: expected %0h, got %0h",
                             i, register_image(RIDX_W'(i)), got));
      end
    end
  endtask

  // Writes to the indexes past the last register must change nothing.
  task automatic write_spare_registers();
    for (int i = REG_OUTPUT_VOLUME + 1; i < 2 ** RIDX_W; i++) begin
      write_register(RIDX_W'(i), $urandom);
    end
  endtask

  // Sends one item. The sender runs in bursts with random gaps in between;
  // valid stays high from one item to the next inside a burst.
  task automatic send_pair(input sample_t l, input sample_t r,
                           input sample_t al, input sample_t ar);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_left_i <= l;
    in_right_i <= r;
    acc_left_i <= al;
    acc_right_i <= ar;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_echo(l, r, al, ar);
    @(negedge clk_i);
  endtask

  // Stops the sender and waits until every expected result has come back.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (mixed_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic sample_t draw_sample(input amp_mode_t mode);
    case (mode)
      AMP_EDGE: begin
        case ($urandom_range(0, 3))
          0:       return sample_t'(SAMPLE_MIN);
          1:       return sample_t'(SAMPLE_MAX);
          2:       return '0;
          default: return '1;
        endcase
      end
      AMP_QUIET: return sample_t'($urandom_range(0, 511) - 256);
      default:   return sample_t'($urandom);
    endcase
  endfunction

  function automatic int unsigned pick_gain();
    case ($urandom_range(0, 4))
      0:       return 0;
      1:       return GAIN_ONE;
      2:       return $urandom_range(0, GAIN_ONE);
      3:       return $urandom_range(GAIN_ONE + 1, 65535);
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Puts random upper bits above a register value; the block must drop them.
  function automatic logic [PDATA_W-1:0] pad_upper(input int unsigned v, input int w);
    return ($urandom << w) | (v & ((32'd1 << w) - 1));
  endfunction

  // Reset values are read back, then the stores start out empty so the
  // results equal the accumulators until the first echo returns.
  task automatic test_reset_defaults();
    check_registers();
    send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN),
              sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX),
              sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    send_pair('1, '0, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    send_pair('0, '1, '0, '0);
    wait_for_results();
  endtask

  // Length below the minimum, a delay longer than the ring, every gain above
  // one, and writes to the unused indexes.
  task automatic test_config_edges();
    write_register(REG_ACTIVE_LENGTH, 32'hFFFF_0000);
    write_register(REG_DELAY_SAMPLES, 32'hFFFF_FFFF);
    write_register(REG_FEEDBACK_GAIN, 32'h0000_FFFF);
    write_register(REG_CROSS_MIX, 32'd40000);
    write_register(REG_OUTPUT_VOLUME, 32'hAAAA_FFFF);
    write_spare_registers();
    check_registers();
    send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX), '1, '0);
    send_pair(sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX), '1);
    send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN),
              sample_t'(SAMPLE_MIN), sample_t'(SAMPLE_MAX));
    send_pair('1, sample_t'(SAMPLE_MAX), '0, sample_t'(SAMPLE_MIN));
    wait_for_results();
  endtask

  // With zero delay each write lands on the entry just read.
  task automatic test_zero_delay();
    write_register(REG_ACTIVE_LENGTH, 32'd3);
    write_register(REG_DELAY_SAMPLES, 32'd0);
    write_register(REG_FEEDBACK_GAIN, GAIN_ONE);
    write_register(REG_CROSS_MIX, 32'd16384);
    write_register(REG_OUTPUT_VOLUME, 32'd16384);
    send_pair(16'sd12000, -16'sd9000, 16'sd100, -16'sd100);
    send_pair(16'sd30000, sample_t'(SAMPLE_MIN), '0, '1);
    send_pair(-16'sd7, 16'sd5, sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MIN));
    send_pair('0, '0, '0, '0);
    wait_for_results();
  endtask

  // A short ring with full cross-feed, then the ring is shrunk below the
  // pointer so the next item starts from the pointer folded into range.
  task automatic test_short_ring();
    write_register(REG_ACTIVE_LENGTH, 32'd8);
    write_register(REG_DELAY_SAMPLES, 32'd5);
    write_register(REG_FEEDBACK_GAIN, 32'd20000);
    write_register(REG_CROSS_MIX, GAIN_ONE);
    write_register(REG_OUTPUT_VOLUME, GAIN_ONE);
    for (int i = 0; i < 6; i++) begin
      send_pair(draw_sample(AMP_FULL), draw_sample(AMP_FULL),
                draw_sample(AMP_QUIET), draw_sample(AMP_QUIET));
    end
    wait_for_results();
    write_register(REG_ACTIVE_LENGTH, 32'd3);
    for (int i = 0; i < 3; i++) begin
      send_pair(draw_sample(AMP_EDGE), draw_sample(AMP_FULL),
                draw_sample(AMP_FULL), draw_sample(AMP_EDGE));
    end
    wait_for_results();
  endtask

  // Random register settings, biased to short rings so echoes come back often.
  task automatic set_random_config();
    int unsigned len_v, eff_len, dly_v;
    case ($urandom_range(0, 7))
      0:       len_v = MIN_LENGTH;
      1:       len_v = 3;
      2:       len_v = $urandom_range(MIN_LENGTH, 16);
      3:       len_v = $urandom_range(MIN_LENGTH, 128);
      4:       len_v = DEPTH;
      5:       len_v = $urandom_range(DEPTH + 1, 65535);
      6:       len_v = $urandom_range(0, MIN_LENGTH - 1);
      default: len_v = $urandom_range(MIN_LENGTH, 1024);
    endcase
    eff_len = (len_v < MIN_LENGTH) ? MIN_LENGTH : (len_v > DEPTH) ? DEPTH : len_v;
    case ($urandom_range(0, 5))
      0:       dly_v = 0;
      1:       dly_v = 1;
      2:       dly_v = eff_len - 1;
      3:       dly_v = DEPTH - 1;
      4:       dly_v = $urandom_range(0, DEPTH - 1);
      default: dly_v = $urandom_range(0, eff_len - 1);
    endcase
    write_register(REG_ACTIVE_LENGTH, pad_upper(len_v, LEN_W));
    write_register(REG_DELAY_SAMPLES, pad_upper(dly_v, ADDR_W));
    write_register(REG_FEEDBACK_GAIN, pad_upper(pick_gain(), GAIN_W));
    write_register(REG_CROSS_MIX, pad_upper(pick_gain(), GAIN_W));
    write_register(REG_OUTPUT_VOLUME, pad_upper(pick_gain(), GAIN_W));
    if ($urandom_range(0, 3) == 0) write_spare_registers();
  endtask

  // Phases of random items, each under a fresh register setting.
  task automatic test_random_phases();
    amp_mode_t style;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      set_random_config();
      check_registers();
      style = amp_mode_t'($urandom_range(0, 2));
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) begin
          send_pair(draw_sample(AMP_FULL), draw_sample(AMP_FULL),
                    draw_sample(AMP_EDGE), draw_sample(AMP_EDGE));
        end else begin
          send_pair(draw_sample(style), draw_sample(style),
                    draw_sample(style), draw_sample(style));
        end
      end
    end
  endtask

  // Receiver stall pattern: free windows, light and heavy random stalls,
  // and periodic blocks of stalled cycles.
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_stall_i <= 1'b0;
      RX_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
      RX_HEAVY: out_stall_i <= ($urandom_range(0, 3) != 0);
      default:  out_stall_i <= ((rx_left % 32) < 12);
    endcase
  end

  // Each accepted result is compared with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    stereo_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mixed_q.size() == 0) begin
        flag_error($sformatf("unexpected result %0d / %0d", out_left_o, out_right_o));
      end else begin
        want = mixed_q.pop_front();
        if (want.left !== out_left_o) begin
          flag_error($sformatf("out_left: expected %0d, got %0d", want.left, out_left_o));
        end
        if (want.right !== out_right_o) begin
          flag_error($sformatf("out_right: expected %0d, got %0d",
                               want.right, out_right_o));
        end
      end
    end
  end

  // Main sequence.
  initial begin
    foreach (echo_l[i]) begin
      echo_l[i] = '0;
      echo_r[i] = '0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_config_edges();
    test_zero_delay();
    test_short_ring();
    test_random_phases();
    wait_for_results();
    repeat (4 * ITEM_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && mixed_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Run limit, several times the slowest legal run including the store clearing.
  initial begin
    #3_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
